/* rtl/hslp_pkg.sv */
// ----------------------------------------------------------------------------
// hslp_pkg: shared constants for the linear-probe hash set insert block
// Field widths, stream packing, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package hslp_pkg;

  // Request and result field widths
  localparam int KEY_TEXT_W  = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int STATUS_W    = 2;
  localparam int CAP_W       = 9;
  localparam int HASH_W      = 32;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  // Hash multiplier
  localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Parameter defaults
  localparam int DEF_TABLE_DEPTH   = 256;
  localparam int DEF_MAX_KEY_BYTES = 8;

endpackage

/* rtl/hslp_hash.sv */
// ----------------------------------------------------------------------------
// hslp_hash: byte-serial key hash
// One key byte a cycle: h = byte + 31*h, stops at the length or a zero byte.
// ----------------------------------------------------------------------------
module hslp_hash #(
  parameter int MAX_KEY_BYTES = hslp_pkg::DEF_MAX_KEY_BYTES,
  parameter int KEY_W         = 8 * MAX_KEY_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [KEY_W-1:0]               key_text,
  input  logic [hslp_pkg::KEY_LEN_W-1:0] key_length,
  output logic                           done,
  output logic [hslp_pkg::HASH_W-1:0]    hash,
  output logic [KEY_W-1:0]               key
);
  import hslp_pkg::*;

  logic [KEY_W-1:0]     text_sh;
  logic [KEY_W-1:0]     key_sh;
  logic [HASH_W-1:0]    h;
  logic [KEY_LEN_W-1:0] len_sat;
  logic [KEY_LEN_W-1:0] cnt;
  logic                 alive;
  logic                 busy;
  logic [7:0]           cur_byte;
  logic                 take;

  assign cur_byte = text_sh[7:0];
  assign take     = alive && (cnt < len_sat) && (cur_byte != 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      alive <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        alive <= 1'b1;
        cnt   <= '0;
      end else if (busy) begin
        alive <= take;
        cnt   <= cnt + KEY_LEN_W'(1);
        if (cnt == KEY_LEN_W'(MAX_KEY_BYTES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload path: shift text out, shift kept bytes into the key
  always_ff @(posedge clk) begin
    if (start) begin
      text_sh <= key_text;
      key_sh  <= '0;
      h       <= '0;
      len_sat <= (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                 KEY_LEN_W'(MAX_KEY_BYTES) : key_length;
    end else if (busy) begin
      text_sh <= text_sh >> 8;
      key_sh  <= (key_sh >> 8) |
                 (KEY_W'(take ? cur_byte : 8'h00) << (KEY_W - 8));
      if (take) begin
        h <= h * HASH_MULT + HASH_W'(cur_byte);
      end
    end
  end

  assign hash = h;
  assign key  = key_sh;

endmodule

/* rtl/hslp_mod.sv */
// ----------------------------------------------------------------------------
// hslp_mod: bit-serial remainder unit
// Restoring remainder of a 32-bit hash by the active capacity, one bit a cycle.
// ----------------------------------------------------------------------------
module hslp_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hslp_pkg::HASH_W-1:0] dividend,
  input  logic [hslp_pkg::CAP_W-1:0]  divisor,
  output logic                        done,
  output logic [hslp_pkg::CAP_W-1:0]  rem
);
  import hslp_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);

  logic [HASH_W-1:0] q;
  logic [CAP_W-1:0]  r;
  logic [CAP_W-1:0]  div;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [CAP_W:0]    sh;
  logic [CAP_W:0]    diff;

  assign sh   = {r, q[HASH_W-1]};
  assign diff = sh - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      div <= divisor;
    end else if (busy) begin
      q <= q << 1;
      r <= (sh >= {1'b0, div}) ? diff[CAP_W-1:0] : sh[CAP_W-1:0];
    end
  end

  assign rem = r;

endmodule

/* rtl/hslp_table.sv */
// ----------------------------------------------------------------------------
// hslp_table: slot store with used flag
// One write and one registered read port; sweeps every slot empty after reset.
// ----------------------------------------------------------------------------
module hslp_table #(
  parameter int TABLE_DEPTH = hslp_pkg::DEF_TABLE_DEPTH,
  parameter int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int KEY_W       = 8 * hslp_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clear_busy,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [KEY_W:0]    rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [KEY_W:0]    wr_data
);
  import hslp_pkg::*;

  logic [KEY_W:0]    mem [TABLE_DEPTH];
  logic [SLOT_W-1:0] clr_addr;
  logic              we;
  logic [SLOT_W-1:0] wa;
  logic [KEY_W:0]    wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  // Sweep has priority over the probe write
  assign we = clear_busy || wr_en;
  assign wa = clear_busy ? clr_addr : wr_addr;
  assign wd = clear_busy ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/hash_set_linear_probe_insert.sv */
// ----------------------------------------------------------------------------
// hash_set_linear_probe_insert: open-addressing hash set insert, linear probing
// Hashes a short text key, reduces it modulo the capacity, then probes slots
// for an empty slot or an equal key and reports inserted/present/full.
// ----------------------------------------------------------------------------
// Steps: hash the key bytes, take the remainder by the capacity, read and
// compare each probed slot, then load the output register; full-table answers
// skip the remainder and the probe walk. Probes run from 1 to capacity slots.
// Throughput: one transaction at a time; set by the bit-serial remainder unit
// and the slot-by-slot probe loop over the slot memory.
// Reset: synchronous; after reset the slot store is swept empty while
// s_tready stays low; capacity resets to 256.
// ----------------------------------------------------------------------------
module hash_set_linear_probe_insert #(
  parameter int TABLE_DEPTH   = hslp_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_KEY_BYTES = hslp_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [hslp_pkg::IN_TDATA_W-1:0]  s_tdata,   // key_text[63:0], key_length[67:64]
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [hslp_pkg::OUT_TDATA_W-1:0] m_tdata,   // status[1:0]
  // Capacity register write
  input  logic                             cfg_wen,
  input  logic [hslp_pkg::CAP_W-1:0]       cfg_wdata
);
  import hslp_pkg::*;

  localparam int SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KEY_W   = 8 * MAX_KEY_BYTES;
  localparam int CAP_MAX = (1 << CAP_W) - 1;
  localparam int MAX_CAP = (TABLE_DEPTH < CAP_MAX) ? TABLE_DEPTH : CAP_MAX;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]          state;
  logic [CAP_W-1:0]    capacity;
  logic [CAP_W-1:0]    act_cap;
  logic [CAP_W-1:0]    key_count;
  logic [SLOT_W-1:0]   idx;
  logic [CAP_W-1:0]    visited;
  logic [STATUS_W-1:0] status;

  logic                in_fire;
  logic                out_free;
  logic                table_full;

  logic                hash_start;
  logic                hash_done;
  logic [HASH_W-1:0]   hash_val;
  logic [KEY_W-1:0]    key_val;

  logic                mod_start;
  logic                mod_done;
  logic [CAP_W-1:0]    mod_rem;

  logic                clear_busy;
  logic                tbl_rd;
  logic [KEY_W:0]      tbl_rdata;
  logic                tbl_wr;
  logic                rd_used;
  logic [KEY_W-1:0]    rd_key;

  logic [31:0]         idx_inc;
  logic [SLOT_W-1:0]   idx_wrap;
  logic [CAP_W-1:0]    visited_inc;

  // Capacity register: zero acts as one slot, clamp to the table depth
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(256);
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      act_cap = CAP_W'(1);
    end else if (capacity > CAP_W'(MAX_CAP)) begin
      act_cap = CAP_W'(MAX_CAP);
    end else begin
      act_cap = capacity;
    end
  end

  // Accept a request only when idle and the sweep is finished
  assign s_tready   = (state == S_IDLE) && !clear_busy;
  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign table_full = key_count >= act_cap;

  assign hash_start = in_fire;
  assign mod_start  = (state == S_HASH) && hash_done && !table_full;

  hslp_hash #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .KEY_W         (KEY_W)
  ) u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (hash_start),
    .key_text   (s_tdata[KEY_W-1:0]),
    .key_length (s_tdata[KEY_TEXT_W +: KEY_LEN_W]),
    .done       (hash_done),
    .hash       (hash_val),
    .key        (key_val)
  );

  hslp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (hash_val),
    .divisor  (act_cap),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Probe memory: read the current slot, write on an empty hit
  assign tbl_rd  = (state == S_READ);
  assign rd_used = tbl_rdata[KEY_W];
  assign rd_key  = tbl_rdata[KEY_W-1:0];
  assign tbl_wr  = (state == S_CMP) && !rd_used;

  hslp_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SLOT_W      (SLOT_W),
    .KEY_W       (KEY_W)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .clear_busy (clear_busy),
    .rd_en      (tbl_rd),
    .rd_addr    (idx),
    .rd_data    (tbl_rdata),
    .wr_en      (tbl_wr),
    .wr_addr    (idx),
    .wr_data    ({1'b1, key_val})
  );

  // Next probe slot, wrapping at the active capacity
  assign idx_inc     = 32'(idx) + 32'd1;
  assign idx_wrap    = (idx_inc >= 32'(act_cap)) ? '0 : SLOT_W'(idx_inc);
  assign visited_inc = visited + CAP_W'(1);

  // Sequencer: hash, reduce, probe, answer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            // Check full before spending cycles on the remainder
            state <= table_full ? S_RESP : S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!rd_used) begin
            key_count <= key_count + CAP_W'(1);
            state     <= S_RESP;
          end else if (rd_key == key_val) begin
            state <= S_RESP;
          end else if (visited_inc == act_cap) begin
            state <= S_RESP;
          end else begin
            state <= S_READ;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Probe position and answer code
  always_ff @(posedge clk) begin
    if ((state == S_HASH) && hash_done) begin
      status <= ST_FULL;
    end
    if ((state == S_MOD) && mod_done) begin
      idx     <= SLOT_W'(mod_rem);
      visited <= '0;
    end
    if (state == S_CMP) begin
      idx     <= idx_wrap;
      visited <= visited_inc;
      if (!rd_used) begin
        status <= ST_INSERTED;
      end else if (rd_key == key_val) begin
        status <= ST_PRESENT;
      end else begin
        status <= ST_FULL;
      end
    end
  end

  // Output register: load when free, drop on the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      m_tdata <= OUT_TDATA_W'(status);
    end
  end

  // Checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !s_tready)
    else $error("request accepted during slot sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CAP_W'(MAX_CAP))
    else $error("key count beyond table size");

  a_write_on_empty: assert property (@(posedge clk) disable iff (rst)
    tbl_wr |-> (!clear_busy && !table_full))
    else $error("slot written while sweeping or with table full");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_RESP))
    else $error("result raised outside answer state");

endmodule

/* tb/hslp_insert_checker.sv */
// ----------------------------------------------------------------------------
// hslp_insert_checker: scoreboard for the linear-probe hash set insert block
// Mirrors the slot store, predicts the status of every accepted request and
// compares it against the result stream in order.
// ----------------------------------------------------------------------------
module hslp_insert_checker
  import hslp_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // key_text[63:0], key_length[67:64]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0]
  input  logic                   cfg_wen,
  input  logic [CAP_W-1:0]       cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  logic [CAP_W-1:0]      model_capacity;
  logic [CAP_W-1:0]      model_key_count;
  logic                  model_used [TABLE_DEPTH];
  logic [KEY_TEXT_W-1:0] model_key  [TABLE_DEPTH];
  logic [STATUS_W-1:0]   status_due [$];

  // Insert one key into the shadow table and return the status it earns.
  function automatic logic [STATUS_W-1:0] insert_key(input logic [KEY_TEXT_W-1:0] text,
                                                     input logic [KEY_LEN_W-1:0]  len);
    int                    cap;
    int                    lim;
    int                    idx;
    int                    n;
    logic [KEY_TEXT_W-1:0] key;
    logic [HASH_W-1:0]     h;
    logic [7:0]            b;
    logic                  ended;
    logic                  done;
    logic [STATUS_W-1:0]   st;
    cap = int'(model_capacity);
    if (cap == 0) cap = 1;
    if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
    lim = (int'(len) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(len);
    key = '0;
    h = '0;
    ended = 1'b0;
    for (n = 0; n < MAX_KEY_BYTES; n++) begin
      if (n < lim && !ended) begin
        b = text[8*n +: 8];
        if (b == 8'h00) begin
          ended = 1'b1;
        end else begin
          key[8*n +: 8] = b;
          h = {24'h0, b} + HASH_MULT * h;
        end
      end
    end
    if (int'(model_key_count) >= cap) return ST_FULL;
    idx = int'(h % HASH_W'(cap));
    st = ST_FULL;
    done = 1'b0;
    for (n = 0; n < cap; n++) begin
      if (!done) begin
        if (!model_used[idx]) begin
          model_used[idx] = 1'b1;
          model_key[idx] = key;
          model_key_count = model_key_count + 1'b1;
          st = ST_INSERTED;
          done = 1'b1;
        end else if (model_key[idx] == key) begin
          st = ST_PRESENT;
          done = 1'b1;
        end else begin
          idx = (idx + 1 >= cap) ? 0 : idx + 1;
        end
      end
    end
    return st;
  endfunction

  always @(posedge clk) begin : monitor
    logic [STATUS_W-1:0] want;
    int in_n;
    int out_n;
    int i;
    in_n = 0;
    out_n = 0;
    if (rst) begin
      model_capacity = CAP_W'(256);
      model_key_count = '0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        model_used[i] = 1'b0;
        model_key[i] = '0;
      end
      status_due.delete();
      pending <= 0;
      mismatches <= 0;
    end else begin
      // results first, so a result never meets the request accepted alongside it
      if (m_tvalid && m_tready) begin
        if (status_due.size() == 0) begin
          if (mismatches < 10)
            $display("mismatch: result status %0d with nothing outstanding",
                     m_tdata[STATUS_W-1:0]);
          mismatches <= mismatches + 1;
        end else begin
          want = status_due.pop_front();
          out_n = 1;
          if (m_tdata[STATUS_W-1:0] !== want) begin
            if (mismatches < 10)
              $display("mismatch: status expected %0d got %0d", want,
                       m_tdata[STATUS_W-1:0]);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_wen) model_capacity = cfg_wdata;
      if (s_tvalid && s_tready) begin
        status_due.push_back(insert_key(s_tdata[KEY_TEXT_W-1:0],
                                        s_tdata[KEY_TEXT_W +: KEY_LEN_W]));
        in_n = 1;
      end
      pending <= pending + in_n - out_n;
    end
  end

endmodule

/* tb/tb_hash_set_linear_probe_insert.sv */
// ----------------------------------------------------------------------------
// tb_hash_set_linear_probe_insert: testbench for the hash set insert block
// Drives directed and random insert requests through a series of capacity
// settings with random idle bursts on both streams; a separate checker
// predicts every status and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_hash_set_linear_probe_insert;
  import hslp_pkg::*;

  // Longest correct silence is the post-reset sweep or one full-table probe
  // walk plus receiver stalls; allow several times that.
  localparam int WATCHDOG_LIMIT = 5000;
  // Tail wait after the last result, covering the slowest transaction.
  localparam int DRAIN_CYCLES   = 700;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tready  = 1'b0;
  logic                   cfg_wen   = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int   mismatches;
  int   pending;
  int   stall_left  = 0;
  int   idle_cycles = 0;
  logic quiet       = 1'b0;   // no idling on either side once set

  // Keys already sent, reused to hit present keys and slot collisions
  logic [KEY_TEXT_W-1:0] sent_text [$];
  logic [KEY_LEN_W-1:0]  sent_len  [$];

  always #2 clk = ~clk;

  hash_set_linear_probe_insert dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  hslp_insert_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Receiver: drop ready in random bursts, counted down in stall_left.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL hash_set_linear_probe_insert");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. An optional
  // idle burst comes first; valid is only lowered when that burst happens.
  task automatic send_request(input logic [KEY_TEXT_W-1:0] text,
                              input logic [KEY_LEN_W-1:0]  len);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, len, text};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and hold until every expected status has come back. The
  // first edge lets the checker count a request accepted at the last edge.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Every request produces a result, so a drained block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // One capacity setting followed by random requests. One in fresh_one_in
  // requests carries a new random key; the rest repeat a sent key with new
  // junk past its end, so the stored key matches again.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int items,
                           input int fresh_one_in);
    logic [KEY_TEXT_W-1:0] text;
    logic [KEY_TEXT_W-1:0] junk;
    logic [KEY_LEN_W-1:0]  len;
    logic                  stop;
    int                    item;
    int                    k;
    int                    n;
    int                    lim;
    int                    e;
    set_capacity(cap);
    for (item = 0; item < items; item++) begin
      if (sent_text.size() == 0 || $urandom_range(1, fresh_one_in) == 1) begin
        text = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) len = KEY_LEN_W'($urandom_range(1, 8));
        else len = KEY_LEN_W'($urandom_range(0, 15));
        // sprinkle zero bytes so keys end early inside the length
        for (n = 0; n < 8; n++)
          if ($urandom_range(0, 23) == 0) text[8*n +: 8] = 8'h00;
        sent_text.push_back(text);
        sent_len.push_back(len);
      end else begin
        k = $urandom_range(0, sent_text.size() - 1);
        text = sent_text[k];
        lim = (sent_len[k] > DEF_MAX_KEY_BYTES) ? DEF_MAX_KEY_BYTES : int'(sent_len[k]);
        // find where the stored key really ends
        e = lim;
        stop = 1'b0;
        for (n = 0; n < 8; n++) begin
          if (!stop && n < lim && text[8*n +: 8] == 8'h00) begin
            e = n;
            stop = 1'b1;
          end
        end
        junk = {$urandom, $urandom};
        for (n = 0; n < 8; n++)
          if (n >= e) text[8*n +: 8] = junk[8*n +: 8];
        len = KEY_LEN_W'($urandom_range(15, e));
        if (int'(len) > e && e < 8) text[8*e +: 8] = 8'h00;
      end
      send_request(text, len);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity of 256.
    send_request(64'h0, 4'd0);                      // empty key
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);    // empty key again, junk text
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);    // all bytes at maximum
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);   // length saturates to 8
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
    send_request(64'h0000_0000_0000_00FF, 4'd1);
    send_request(64'h0000_0000_0000_0001, 4'd1);
    send_request(64'h7777_6666_0000_4241, 4'd6);    // zero byte ends the key early
    send_request(64'h0000_0000_0000_4241, 4'd2);    // same key, exact length
    send_request(64'h0000_0000_0000_4241, 4'd15);
    send_request(64'h8000_0000_0000_0000, 4'd8);    // leading zero: empty key
    send_request(64'h0102_0304_0506_0708, 4'd8);
    send_request(64'h0102_0304_0506_0708, 4'd7);    // shorter prefix is a new key
    send_request(64'h5555_AAAA_5555_AAAA, 4'd8);
    send_request(64'hAAAA_5555_AAAA_5555, 4'd4);

    // Capacity extremes below the stored count answer full.
    set_capacity(9'd1);
    send_request(64'h0, 4'd0);
    send_request(64'h0000_0000_0000_0033, 4'd1);
    set_capacity(9'd0);                             // treated as one slot
    send_request(64'h0000_0000_0000_0044, 4'd1);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);

    // Random part: capacities mostly rising, since the stored count never
    // drops; the lowered settings exercise slots left beyond the capacity.
    run_phase(9'd1,   30,  3);
    run_phase(9'd0,   30,  3);
    run_phase(9'd12,  60,  3);
    run_phase(9'd40,  150, 4);
    run_phase(9'd9,   60,  3);
    run_phase(9'd100, 250, 5);
    run_phase(9'd300, 150, 5);                      // saturates to 256
    run_phase(9'd256, 350, 6);
    run_phase(9'd511, 150, 6);
    run_phase(9'd160, 150, 5);
    wait_drained();
    quiet <= 1'b1;                                  // no idling from here on
    run_phase(9'd256, 200, 6);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS hash_set_linear_probe_insert");
    end else begin
      $display("FAIL hash_set_linear_probe_insert");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hslp_pkg.sv
rtl/hslp_hash.sv
rtl/hslp_mod.sv
rtl/hslp_table.sv
rtl/hash_set_linear_probe_insert.sv
tb/hslp_insert_checker.sv
tb/tb_hash_set_linear_probe_insert.sv
